/* src/timed_overlay_presentation_queue_macros.svh */
// assertion macros for the timed overlay presentation queue
// expects clk and arst_n in the scope of use
`ifndef TIMED_OVERLAY_PRESENTATION_QUEUE_MACROS_SVH
`define TIMED_OVERLAY_PRESENTATION_QUEUE_MACROS_SVH
// condition holds at every edge out of reset
`define TOPQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define TOPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`endif

/* src/topq_pkg.sv */
// shared types and constants for the timed overlay presentation queue
// no dependencies
package topq_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TAG_W = 8;
	localparam int TIME_W = 47;
	localparam int STIME_W = 48;
	localparam int ENTRY_W = TAG_W + 4 * TIME_W;
	localparam logic [4:0] LIMIT_RESET = 5'd16;
	localparam logic [23:0] PERIOD_RESET = 24'd400000;
	localparam logic [1:0] REG_LIMIT = 2'd0;
	localparam logic [1:0] REG_PERIOD = 2'd1;

	typedef enum logic [1:0] {
		KIND_ENQ = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_INVAL = 2'd2,
		KIND_SETTIME = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_LK_RD, S_LK_EV, S_IV_RD, S_IV_EV, S_HD_RD, S_TL_RD, S_DONE
	} state_t;

	typedef enum logic {RD_HEAD, RD_TAIL} rd_sel_t;

	typedef struct packed {
		logic load;
		logic start;
		logic lk_ev;
		logic iv_ev;
		rd_sel_t rd;
		logic cap_head;
		logic finish;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic lk_done;
		logic occ_zero;
		logic st_inv;
		logic iv_pop;
		logic out_free;
	} status_t;
endpackage

/* src/topq_ram.sv */
// generic single write, single registered read memory
// no dependencies
module topq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* src/topq_ctrl.sv */
// sequencing state machine for the timed overlay presentation queue
// depends on topq_pkg
module topq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  topq_pkg::status_t st,
	output logic in_ready,
	output topq_pkg::cmd_t cmd
);
	topq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= topq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd = topq_pkg::RD_HEAD;
		in_ready = 1'b0;
		case (state_q)
			topq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = topq_pkg::S_START;
				end
			end
			topq_pkg::S_START: begin
				cmd.start = 1'b1;
				case (st.kind)
					topq_pkg::KIND_ENQ: state_d = topq_pkg::S_HD_RD;
					topq_pkg::KIND_LOOKUP: state_d = topq_pkg::S_LK_RD;
					topq_pkg::KIND_INVAL: state_d = topq_pkg::S_IV_RD;
					default: state_d = st.st_inv ? topq_pkg::S_IV_RD : topq_pkg::S_HD_RD;
				endcase
			end
			topq_pkg::S_LK_RD: begin
				state_d = (st.lk_done || st.occ_zero) ? topq_pkg::S_HD_RD : topq_pkg::S_LK_EV;
			end
			topq_pkg::S_LK_EV: begin
				cmd.lk_ev = 1'b1;
				state_d = topq_pkg::S_LK_RD;
			end
			topq_pkg::S_IV_RD: begin
				cmd.rd = topq_pkg::RD_TAIL;
				state_d = st.occ_zero ? topq_pkg::S_HD_RD : topq_pkg::S_IV_EV;
			end
			topq_pkg::S_IV_EV: begin
				cmd.iv_ev = 1'b1;
				state_d = st.iv_pop ? topq_pkg::S_IV_RD : topq_pkg::S_HD_RD;
			end
			topq_pkg::S_HD_RD: begin
				state_d = topq_pkg::S_TL_RD;
			end
			topq_pkg::S_TL_RD: begin
				cmd.rd = topq_pkg::RD_TAIL;
				cmd.cap_head = 1'b1;
				state_d = topq_pkg::S_DONE;
			end
			topq_pkg::S_DONE: begin
				cmd.rd = topq_pkg::RD_TAIL;
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d = topq_pkg::S_IDLE;
				end
			end
			default: state_d = topq_pkg::S_IDLE;
		endcase
	end
endmodule

/* src/topq_dp.sv */
// queue datapath: state registers, entry memory, decisions, result register
// depends on topq_pkg, topq_ram and the assertion macro header
`include "timed_overlay_presentation_queue_macros.svh"
module topq_dp (
	input  logic clk,
	input  logic arst_n,
	input  topq_pkg::cmd_t cmd,
	output topq_pkg::status_t st,
	input  logic [1:0] in_kind,
	input  logic [47:0] in_when,
	input  logic [7:0] in_tag,
	input  logic [46:0] in_start,
	input  logic [46:0] in_stop,
	input  logic [46:0] in_seg_start,
	input  logic [46:0] in_seg_stop,
	input  logic in_seg_given,
	input  logic in_new_pass,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [23:0] cfg_wdata,
	input  logic out_ready,
	output logic out_valid,
	output logic [204:0] out_bits
);
	localparam int TW = topq_pkg::TIME_W;

	topq_pkg::kind_t kind_q;
	logic signed [47:0] when_q;
	logic [7:0] e_tag_q;
	logic [TW-1:0] e_start_q, e_stop_q, e_ss_q, e_sp_q;
	logic np_q;
	logic [topq_pkg::IDX_W-1:0] head_q;
	logic [topq_pkg::CNT_W-1:0] occ_q;
	logic sv_q;
	logic [7:0] sh_tag_q;
	logic [TW-1:0] sh_start_q, sh_stop_q, sh_ss_q, sh_sp_q;
	logic signed [47:0] now_q, prev_q, ipt_q;
	logic pend_q;
	logic [4:0] limit_q;
	logic [23:0] period_q;
	logic found_q, acc_q, done_q;
	logic [7:0] ftag_q;
	logic [TW-1:0] head_start_q;
	logic out_valid_q;
	logic [204:0] out_q;

	logic [topq_pkg::ENTRY_W-1:0] rdata, wdata;
	logic [topq_pkg::IDX_W-1:0] raddr, waddr;
	logic we;
	logic [7:0] rd_tag;
	logic [TW-1:0] rd_start, rd_stop, rd_ss, rd_sp;
	logic signed [47:0] r_start, r_stop, r_ss, r_sp;
	logic signed [47:0] s_start, s_stop, s_ss, s_sp;
	logic [4:0] lim;
	logic enq_ok, pend_eff;
	logic signed [48:0] seek_back;
	logic st_inv, sh_kill;
	logic pick, drop, ldone;
	logic signed [47:0] tail_s, rend;
	logic [TW-1:0] tail_v;

	assign rd_tag = rdata[7:0];
	assign rd_start = rdata[8 +: TW];
	assign rd_stop = rdata[8 + TW +: TW];
	assign rd_ss = rdata[8 + 2 * TW +: TW];
	assign rd_sp = rdata[8 + 3 * TW +: TW];
	assign r_start = $signed({1'b0, rd_start});
	assign r_stop = $signed({1'b0, rd_stop});
	assign r_ss = $signed({1'b0, rd_ss});
	assign r_sp = $signed({1'b0, rd_sp});
	assign s_start = $signed({1'b0, sh_start_q});
	assign s_stop = $signed({1'b0, sh_stop_q});
	assign s_ss = $signed({1'b0, sh_ss_q});
	assign s_sp = $signed({1'b0, sh_sp_q});

	assign raddr = (cmd.rd == topq_pkg::RD_HEAD) ? head_q
		: head_q + occ_q[topq_pkg::IDX_W-1:0] - 1'b1;
	assign waddr = head_q + occ_q[topq_pkg::IDX_W-1:0];
	assign wdata = {e_sp_q, e_ss_q, e_stop_q, e_start_q, e_tag_q};

	assign lim = (limit_q > 5'(topq_pkg::DEPTH)) ? 5'(topq_pkg::DEPTH) : limit_q;
	assign pend_eff = pend_q && !np_q;
	assign enq_ok = (occ_q < lim) && !(pend_eff && ($signed({1'b0, e_stop_q}) > ipt_q));
	assign we = cmd.start && (kind_q == topq_pkg::KIND_ENQ) && enq_ok;

	assign seek_back = $signed({prev_q[47], prev_q}) - $signed({when_q[47], when_q});
	assign st_inv = !prev_q[47] && (seek_back >= $signed({25'b0, period_q}));
	assign sh_kill = sv_q && (s_stop > when_q);

	// one head entry of the lookup walk
	always_comb begin
		pick = 1'b0;
		drop = 1'b1;
		ldone = 1'b0;
		if (r_ss > when_q) begin
			drop = 1'b0;
			ldone = 1'b1;
		end else if (r_sp > when_q) begin
			if (r_start <= when_q && when_q < r_stop) begin
				pick = 1'b1;
				ldone = 1'b1;
			end else if (when_q >= r_stop) begin
				pick = 1'b1;
			end else begin
				ldone = 1'b1;
				if (!found_q || s_stop <= when_q) begin
					pick = 1'b1;
				end else begin
					drop = 1'b0;
				end
			end
		end
	end

	assign tail_v = (occ_q == '0) ? '0 : rd_stop;
	assign tail_s = (occ_q == '0) ? -48'sd1 : $signed({1'b0, rd_stop});
	assign rend = (tail_s > now_q) ? tail_s : now_q;

	assign st.kind = kind_q;
	assign st.lk_done = done_q;
	assign st.occ_zero = (occ_q == '0);
	assign st.st_inv = st_inv;
	assign st.iv_pop = r_stop > ipt_q;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_bits = out_q;

	topq_ram #(.WIDTH(topq_pkg::ENTRY_W), .DEPTH(topq_pkg::DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= topq_pkg::KIND_ENQ;
			when_q <= '0;
			e_tag_q <= '0; e_start_q <= '0; e_stop_q <= '0; e_ss_q <= '0; e_sp_q <= '0;
			np_q <= 1'b0;
			head_q <= '0;
			occ_q <= '0;
			sv_q <= 1'b0;
			sh_tag_q <= '0; sh_start_q <= '0; sh_stop_q <= '0; sh_ss_q <= '0; sh_sp_q <= '0;
			now_q <= '0;
			prev_q <= -48'sd1;
			pend_q <= 1'b0;
			ipt_q <= '0;
			limit_q <= topq_pkg::LIMIT_RESET;
			period_q <= topq_pkg::PERIOD_RESET;
			found_q <= 1'b0; acc_q <= 1'b0; done_q <= 1'b0; ftag_q <= '0;
			head_start_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == topq_pkg::REG_LIMIT) begin
					limit_q <= cfg_wdata[4:0];
				end else if (cfg_idx == topq_pkg::REG_PERIOD) begin
					period_q <= cfg_wdata;
				end
			end
			if (cmd.load) begin
				kind_q <= topq_pkg::kind_t'(in_kind);
				when_q <= $signed(in_when);
				e_tag_q <= in_tag;
				e_start_q <= in_start;
				e_stop_q <= in_stop;
				e_ss_q <= in_seg_given ? in_seg_start : in_start;
				e_sp_q <= in_seg_given ? in_seg_stop : in_stop;
				np_q <= in_new_pass;
				found_q <= 1'b0; acc_q <= 1'b0; done_q <= 1'b0; ftag_q <= '0;
			end
			if (cmd.start) begin
				case (kind_q)
					topq_pkg::KIND_ENQ: begin
						if (np_q) begin
							pend_q <= 1'b0;
						end
						if (enq_ok) begin
							occ_q <= occ_q + 1'b1;
							acc_q <= 1'b1;
						end
					end
					topq_pkg::KIND_LOOKUP: begin
						if (sv_q) begin
							if (s_ss <= when_q && when_q < s_sp) begin
								found_q <= 1'b1;
								ftag_q <= sh_tag_q;
								done_q <= (s_start <= when_q) && (when_q < s_stop);
							end else if (s_sp <= when_q) begin
								sv_q <= 1'b0;
							end
						end
					end
					topq_pkg::KIND_INVAL: begin
						pend_q <= 1'b1;
						ipt_q <= when_q;
						prev_q <= -48'sd1;
						if (sh_kill) begin
							sv_q <= 1'b0;
						end
						if (!when_q[47] && when_q < now_q) begin
							now_q <= when_q;
						end
					end
					default: begin
						now_q <= when_q;
						prev_q <= when_q;
						if (st_inv) begin
							pend_q <= 1'b1;
							ipt_q <= when_q;
							if (sh_kill) begin
								sv_q <= 1'b0;
							end
						end
					end
				endcase
			end
			if (cmd.lk_ev) begin
				if (pick) begin
					sv_q <= 1'b1;
					sh_tag_q <= rd_tag; sh_start_q <= rd_start; sh_stop_q <= rd_stop;
					sh_ss_q <= rd_ss; sh_sp_q <= rd_sp;
					found_q <= 1'b1;
					ftag_q <= rd_tag;
				end
				if (drop) begin
					head_q <= head_q + 1'b1;
					occ_q <= occ_q - 1'b1;
				end
				if (ldone) begin
					done_q <= 1'b1;
				end
			end
			if (cmd.iv_ev && st.iv_pop) begin
				occ_q <= occ_q - 1'b1;
			end
			if (cmd.cap_head) begin
				head_start_q <= (occ_q == '0) ? '0 : rd_start;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				out_q <= {rend, tail_v, head_start_q, now_q, occ_q, acc_q, ftag_q, found_q};
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TOPQ_ASSERT_ALWAYS(a_occ_bound, occ_q <= topq_pkg::CNT_W'(topq_pkg::DEPTH), "occupancy beyond depth")
	`TOPQ_ASSERT_IMPL(a_acc_kind, acc_q, kind_q == topq_pkg::KIND_ENQ, "accept outside enqueue")
	`TOPQ_ASSERT_IMPL(a_found_kind, found_q, kind_q == topq_pkg::KIND_LOOKUP, "found outside lookup")
endmodule

/* src/timed_overlay_presentation_queue.sv */
// timed overlay presentation queue, top level
// every request passes the load, start, head read and tail read states before its result is registered;
// lookup first examines head entries and invalidate first removes tail entries, with one read and one
// evaluate state per entry; a backward seek by at least the period runs as an invalidate
// one request at a time, the next taken from the cycle after the result is registered
// reset clears the queue, shown entry, times and restores limit 16 and period 400000
module timed_overlay_presentation_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// when, entry_tag, entry_start, entry_stop, segment_start, segment_stop,
	// segment_given, new_pass
	input  logic [247:0] s_axis_tdata,
	// kind
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// found, found_tag, accepted, entry_count, current_time, head_start, tail_stop,
	// rendering_time
	output logic [207:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [23:0] cfg_data
);
	topq_pkg::cmd_t cmd;
	topq_pkg::status_t st;
	logic [204:0] out_bits;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {3'b000, out_bits};

	topq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .st(st),
		.in_ready(s_axis_tready), .cmd(cmd)
	);

	topq_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_kind(s_axis_tuser),
		.in_when(s_axis_tdata[47:0]),
		.in_tag(s_axis_tdata[55:48]),
		.in_start(s_axis_tdata[102:56]),
		.in_stop(s_axis_tdata[149:103]),
		.in_seg_start(s_axis_tdata[196:150]),
		.in_seg_stop(s_axis_tdata[243:197]),
		.in_seg_given(s_axis_tdata[244]),
		.in_new_pass(s_axis_tdata[245]),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_wdata(cfg_data),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_bits(out_bits)
	);
endmodule

/* tb/tb_timed_overlay_presentation_queue.sv */
// self-checking testbench for timed_overlay_presentation_queue
// a scoreboard class predicts every result from accepted requests; depends on topq_pkg
// and the block under test
module tb_timed_overlay_presentation_queue;
	typedef struct {
		topq_pkg::kind_t kind;
		logic [47:0] at;
		logic [7:0] tag;
		logic [46:0] start, stop, seg_start, seg_stop;
		logic seg_given, new_pass;
	} request_t;

	typedef struct {
		bit [7:0] tag;
		longint start, stop, seg_start, seg_stop;
	} overlay_t;

	typedef struct {
		bit found;
		bit [7:0] found_tag;
		bit accepted;
		bit [4:0] count;
		bit [47:0] now;
		bit [46:0] head_start, tail_stop;
		bit [47:0] rendering;
	} answer_t;

	class queue_scoreboard;
		overlay_t slots[topq_pkg::DEPTH];
		int unsigned head, occ;
		bit shown_valid;
		overlay_t shown;
		longint now_t, prev_now, inv_point;
		bit inv_pending;
		int unsigned limit;
		longint period;
		answer_t expected[$];
		int faults;

		function void clear();
			head = 0; occ = 0; shown_valid = 0; shown = '{default: 0};
			now_t = 0; prev_now = -1; inv_pending = 0; inv_point = 0;
			limit = 16; period = 400000; faults = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] val);
			if (idx == topq_pkg::REG_LIMIT)
				limit = {27'd0, val[4:0]};
			else if (idx == topq_pkg::REG_PERIOD)
				period = longint'(val);
		endfunction

		function int unsigned slot_at(int unsigned i);
			return (head + i) % topq_pkg::DEPTH;
		endfunction

		function void invalidate(longint w);
			inv_pending = 1;
			inv_point = w;
			prev_now = -1;
			if (shown_valid && shown.stop > w)
				shown_valid = 0;
			while (occ > 0 && slots[slot_at(occ - 1)].stop > w)
				occ--;
			if (w >= 0 && w < now_t)
				now_t = w;
		endfunction

		function bit lookup(longint t, output overlay_t pick);
			bit found, done, drop;
			overlay_t e;
			found = 0; done = 0;
			pick = '{default: 0};
			if (shown_valid) begin
				if (shown.seg_start <= t && t < shown.seg_stop) begin
					pick = shown; found = 1;
					if (shown.start <= t && t < shown.stop)
						done = 1;
				end else if (shown.seg_stop <= t) begin
					shown_valid = 0;
				end
			end
			while (!done && occ > 0) begin
				e = slots[head];
				drop = 1;
				if (e.seg_start > t)
					break;
				if (e.seg_stop > t) begin
					if (e.start <= t && t < e.stop) begin
						pick = e; found = 1; done = 1;
					end else if (t >= e.stop) begin
						pick = e; found = 1;
					end else begin
						if (!found || pick.stop <= t) begin
							pick = e; found = 1;
						end else begin
							drop = 0;
						end
						done = 1;
					end
				end
				if (drop) begin
					head = (head + 1) % topq_pkg::DEPTH;
					occ--;
				end
			end
			if (found) begin
				shown = pick;
				shown_valid = 1;
			end
			return found;
		endfunction

		function void note_request(request_t r);
			answer_t a;
			overlay_t e, p;
			longint w, tail, rend;
			int unsigned lim;
			a = '{default: 0};
			w = longint'(signed'(r.at));
			lim = limit > topq_pkg::DEPTH ? topq_pkg::DEPTH : limit;
			case (r.kind)
				topq_pkg::KIND_ENQ: begin
					e.tag = r.tag;
					e.start = longint'(r.start);
					e.stop = longint'(r.stop);
					e.seg_start = r.seg_given ? longint'(r.seg_start) : e.start;
					e.seg_stop = r.seg_given ? longint'(r.seg_stop) : e.stop;
					if (r.new_pass)
						inv_pending = 0;
					if (occ < lim && !(inv_pending && e.stop > inv_point)) begin
						slots[slot_at(occ)] = e;
						occ++;
						a.accepted = 1;
					end
				end
				topq_pkg::KIND_LOOKUP: begin
					if (lookup(w, p)) begin
						a.found = 1;
						a.found_tag = p.tag;
					end
				end
				topq_pkg::KIND_INVAL: invalidate(w);
				default: begin
					now_t = w;
					if (prev_now >= 0 && prev_now - now_t >= period)
						invalidate(now_t);
					prev_now = now_t;
				end
			endcase
			tail = occ ? slots[slot_at(occ - 1)].stop : -1;
			rend = tail > now_t ? tail : now_t;
			a.count = 5'(occ);
			a.now = now_t[47:0];
			a.head_start = occ ? slots[head].start[46:0] : '0;
			a.tail_stop = occ ? tail[46:0] : '0;
			a.rendering = rend[47:0];
			expected.push_back(a);
		endfunction

		function void check_result(logic [207:0] d);
			answer_t x, g;
			g.found = d[0];
			g.found_tag = d[8:1];
			g.accepted = d[9];
			g.count = d[14:10];
			g.now = d[62:15];
			g.head_start = d[109:63];
			g.tail_stop = d[156:110];
			g.rendering = d[204:157];
			if (expected.size() == 0) begin
				$display("%0t unexpected result, expected none, actual %h", $time, d);
				faults++;
				return;
			end
			x = expected.pop_front();
			if (x.found !== g.found) report("found", x.found, g.found);
			if (x.found_tag !== g.found_tag) report("found_tag", x.found_tag, g.found_tag);
			if (x.accepted !== g.accepted) report("accepted", x.accepted, g.accepted);
			if (x.count !== g.count) report("entry_count", x.count, g.count);
			if (x.now !== g.now) report("current_time", x.now, g.now);
			if (x.head_start !== g.head_start) report("head_start", x.head_start, g.head_start);
			if (x.tail_stop !== g.tail_stop) report("tail_stop", x.tail_stop, g.tail_stop);
			if (x.rendering !== g.rendering) report("rendering_time", x.rendering, g.rendering);
		endfunction

		function void report(string f, logic [63:0] x, logic [63:0] g);
			$display("%0t %s expected %h actual %h", $time, f, x, g);
			faults++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [247:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [207:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	queue_scoreboard sb = new();
	bit quiet = 0;
	longint base_t = 1000;

	timed_overlay_presentation_queue i_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		m_axis_tready <= quiet || $urandom_range(99) >= 11;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_request(request_t r);
		s_axis_tvalid <= 1;
		s_axis_tuser <= r.kind;
		s_axis_tdata <= {2'b0, r.new_pass, r.seg_given, r.seg_stop, r.seg_start, r.stop,
			r.start, r.tag, r.at};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(r);
		if (!quiet && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 0;
		do @(posedge clk); while (sb.expected.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [47:0] wide_rand();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic request_t make_request(topq_pkg::kind_t k, longint at);
		request_t r;
		r.kind = k;
		r.at = at[47:0];
		r.tag = 8'($urandom);
		r.start = 0; r.stop = 0; r.seg_start = 0; r.seg_stop = 0;
		r.seg_given = 0; r.new_pass = 0;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		longint s;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 6) begin
			r = make_request(topq_pkg::kind_t'($urandom_range(3)),
				longint'(signed'(wide_rand())));
			if ($urandom_range(1))
				r.at = {1'b0, r.at[46:0]};
			r.start = 47'(wide_rand()); r.stop = 47'(wide_rand());
			r.seg_start = 47'(wide_rand()); r.seg_stop = 47'(wide_rand());
			r.seg_given = 1'($urandom); r.new_pass = 1'($urandom);
			return r;
		end
		if (pick < 50) begin
			s = base_t + $urandom_range(0, 40);
			r = make_request(topq_pkg::KIND_ENQ, 0);
			r.start = 47'(s);
			r.stop = $urandom_range(9) == 0 ? 47'(s - $urandom_range(0, 20))
				: 47'(s + $urandom_range(1, 60));
			r.seg_given = $urandom_range(3) == 0;
			r.seg_start = 47'(s - $urandom_range(0, 30));
			r.seg_stop = 47'(r.stop + $urandom_range(0, 30));
			r.new_pass = $urandom_range(4) == 0;
			base_t += $urandom_range(0, 40);
		end else if (pick < 80) begin
			r = make_request(topq_pkg::KIND_LOOKUP, base_t - 60 + $urandom_range(0, 120));
		end else if (pick < 88) begin
			r = make_request(topq_pkg::KIND_INVAL,
				$urandom_range(5) == 0 ? -1 : base_t - $urandom_range(0, 100));
		end else begin
			r = make_request(topq_pkg::KIND_SETTIME, base_t - $urandom_range(0, 400) + 100);
		end
		return r;
	endfunction

	initial begin
		request_t r;
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		r = make_request(topq_pkg::KIND_ENQ, 0);
		r.tag = 8'hff; r.start = '1; r.stop = '1; r.seg_start = '1; r.seg_stop = '1;
		r.seg_given = 1; r.new_pass = 1;
		send_request(r);
		r = make_request(topq_pkg::KIND_LOOKUP, 48'h7fff_ffff_ffff); send_request(r);
		r = make_request(topq_pkg::KIND_LOOKUP, -1); send_request(r);
		r = make_request(topq_pkg::KIND_SETTIME, 48'h7fff_ffff_ffff); send_request(r);
		r = make_request(topq_pkg::KIND_SETTIME, 0); send_request(r);
		r = make_request(topq_pkg::KIND_INVAL, -1); send_request(r);
		r = make_request(topq_pkg::KIND_ENQ, 0); r.tag = 0; r.start = 5; r.stop = 9;
		send_request(r);
		r.new_pass = 1; send_request(r);
		r = make_request(topq_pkg::KIND_ENQ, 0); r.start = 20; r.stop = 10; send_request(r);
		r = make_request(topq_pkg::KIND_ENQ, 0); r.start = 30; r.stop = 40;
		r.seg_given = 1; r.seg_start = 25; r.seg_stop = 50; send_request(r);
		r = make_request(topq_pkg::KIND_LOOKUP, 7); send_request(r);
		r = make_request(topq_pkg::KIND_LOOKUP, 27); send_request(r);
		r = make_request(topq_pkg::KIND_LOOKUP, 45); send_request(r);
		r = make_request(topq_pkg::KIND_LOOKUP, 100); send_request(r);
		for (int i = 0; i < 18; i++) begin
			r = make_request(topq_pkg::KIND_ENQ, 0); r.start = 47'(200 + i);
			r.stop = 47'(201 + i);
			send_request(r);
		end
		r = make_request(topq_pkg::KIND_INVAL, 205); send_request(r);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(topq_pkg::REG_LIMIT, 1); write_reg(topq_pkg::REG_PERIOD, 1); end
				1: begin write_reg(topq_pkg::REG_LIMIT, 16);
					write_reg(topq_pkg::REG_PERIOD, 24'hffffff); end
				2: begin write_reg(topq_pkg::REG_LIMIT, 31); write_reg(topq_pkg::REG_PERIOD, 0); end
				3: begin write_reg(topq_pkg::REG_LIMIT, 0);
					write_reg(topq_pkg::REG_PERIOD, 150); end
				4: begin write_reg(topq_pkg::REG_LIMIT, 24'($urandom_range(1, 16)));
					write_reg(topq_pkg::REG_PERIOD, 24'($urandom_range(1, 300))); end
				default: begin write_reg(topq_pkg::REG_LIMIT, 4);
					write_reg(topq_pkg::REG_PERIOD, 100); end
			endcase
			quiet = ph == 2;
			for (int i = 0; i < (ph == 3 ? 40 : 160); i++)
				send_request(random_request());
			quiet = 0;
			settle();
		end

		if (sb.faults == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* timed_overlay_presentation_queue.f */
+incdir+src
src/topq_pkg.sv
src/topq_ram.sv
src/topq_ctrl.sv
src/topq_dp.sv
src/timed_overlay_presentation_queue.sv
tb/tb_timed_overlay_presentation_queue.sv
